[rtl/tps_pkg.sv]
// Shared constants and types for the timer prescaler search block.
// Used by tps_divider, tps_multiplier and timer_prescaler_top_search.
package tps_pkg;

  // Number of prescaler candidates and the index width.
  localparam int unsigned NumPresc = 8;
  localparam int unsigned IdxW     = 3;

  // Width of prescaler * 1000; the largest is 1024000, below 2^20.
  localparam int unsigned DivW = 20;

  // Prescaler times milliseconds per second, indexed like the list 1,2,4,8,16,64,256,1024.
  localparam logic [DivW-1:0] DIV_TABLE [NumPresc] = '{
    20'd1000, 20'd2000, 20'd4000, 20'd8000,
    20'd16000, 20'd64000, 20'd256000, 20'd1024000
  };

  // Largest usable top value of the 16-bit counter.
  localparam logic [31:0] TOP_LIMIT = 32'd65535;

  // Divider step counts: a full 64-bit quotient, and a 37-bit quotient for
  // the achieved period (prescaler * 1000 * ticks fits in 37 bits).
  localparam int unsigned CntW       = 7;
  localparam logic [CntW-1:0] STEPS_RECIP  = 7'd64;
  localparam logic [CntW-1:0] STEPS_PERIOD = 7'd37;

  // Width of prescaler * 1000 * ticks and the left shift that aligns it.
  localparam int unsigned ProdW = 37;
  localparam int unsigned AlignW = 64 - ProdW;

  // Request to the serial divider.
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] steps;
  } div_req_t;

  // Status of a serial unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[rtl/tps_divider.sv]
// Bit-serial restoring divider: 64-bit dividend, 32-bit divisor.
// One quotient bit per cycle; depends on tps_pkg.
module tps_divider (
  input  logic                clk,
  input  logic                rst,
  input  tps_pkg::div_req_t   req,
  input  logic [63:0]         dividend,
  input  logic [31:0]         divisor,
  output tps_pkg::unit_stat_t stat,
  output logic [63:0]         quotient
);

  logic [63:0]               quo;
  logic [31:0]               rem;
  logic [31:0]               dvsr;
  logic [tps_pkg::CntW-1:0]  cnt;
  logic                      busy;
  logic                      done;
  logic [32:0]               shifted;
  logic [32:0]               diff;

  // Trial subtraction of the held divisor from the shifted remainder.
  assign shifted = {rem, quo[63]};
  assign diff    = shifted - {1'b0, dvsr};

  // Control: a step count runs down while busy; done pulses after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == tps_pkg::CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits leave at the top, quotient bits enter at the bottom.
  // The divisor is captured with the dividend and held for the whole run.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  // A new request never arrives while a division is running.
  assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");

  // Done follows the final step of a run.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

  // The remainder always stays below the divisor during a run.
  assert property (@(posedge clk) disable iff (rst)
    busy && !$past(req.start) |-> rem < dvsr)
    else $error("divider remainder out of range");

endmodule

[rtl/tps_multiplier.sv]
// Bit-serial shift-add multiplier: 64-bit by 32-bit, product kept mod 2^64.
// Takes one multiplier bit per cycle, most significant first; depends on tps_pkg.
module tps_multiplier (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         mcand,
  input  logic [31:0]         mplier,
  output tps_pkg::unit_stat_t stat,
  output logic [63:0]         product
);

  logic [63:0] acc;
  logic [63:0] mc;
  logic [31:0] mr;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;

  // Control: 32 steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: double the sum and add the multiplicand for each set bit.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= mcand;
      mr  <= mplier;
    end else if (busy) begin
      acc <= {acc[62:0], 1'b0} + (mr[31] ? mc : 64'd0);
      mr  <= {mr[30:0], 1'b0};
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

  // A new product never starts while one is running.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");

  // Done follows the final step of a run.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy) && !busy)
    else $error("multiplier done without a finished run");

  // The step count is zero whenever the unit is idle.
  assert property (@(posedge clk) disable iff (rst) !busy && !$past(start) |-> cnt == 6'd0)
    else $error("multiplier count left over");

endmodule

[rtl/timer_prescaler_top_search.sv]
// Timer prescaler search: one beat in, one beat out, one item at a time.
// Each candidate runs a 64-step reciprocal division, a 32-step multiply and, if its
// tick count fits, a 37-step period division on the bit-serial units, plus sequencing.
// Up to eight candidates are tried per item; a finished beat waits in the output register
// while the next item is taken.
// Synchronous reset clears the state machine, the output valid and the serial units' control; nothing else.
module timer_prescaler_top_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] period_ms,
  input  logic [31:0] clock_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        failed,
  output logic [2:0]  prescaler_index,
  output logic [15:0] top_value
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RECIP  = 9'b000000010,
    S_RWAIT  = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_PDIV   = 9'b000100000,
    S_PWAIT  = 9'b001000000,
    S_EVAL   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [31:0]                   period;
  logic [31:0]                   clk_hz;
  logic [tps_pkg::IdxW-1:0]      k;
  logic [31:0]                   ticks;
  logic [tps_pkg::ProdW-1:0]     pprod;
  logic [31:0]                   err;
  logic                          found;
  logic [31:0]                   best_err;
  logic [tps_pkg::IdxW-1:0]      best_idx;
  logic [15:0]                   best_top;

  tps_pkg::div_req_t             div_req;
  logic [63:0]                   div_dividend;
  logic [31:0]                   div_divisor;
  tps_pkg::unit_stat_t           div_stat;
  logic [63:0]                   div_quo;
  logic                          mul_start;
  tps_pkg::unit_stat_t           mul_stat;
  logic [63:0]                   mul_prod;

  logic [31:0]                   tm1;
  logic [31:0]                   pdiff;
  logic                          out_free;

  assign tm1      = ticks - 32'd1;
  assign pdiff    = div_quo[31:0] - period;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Divider operands: the reciprocal in S_RECIP, the achieved period in S_PDIV.
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = tps_pkg::STEPS_RECIP;
    div_dividend  = {clk_hz, 32'd0};
    div_divisor   = {12'd0, tps_pkg::DIV_TABLE[k]};
    if (state == S_RECIP) begin
      div_req.start = 1'b1;
    end else if (state == S_PDIV) begin
      div_req.start = 1'b1;
      div_req.steps = tps_pkg::STEPS_PERIOD;
      div_dividend  = {pprod, {tps_pkg::AlignW{1'b0}}};
      div_divisor   = clk_hz;
    end
  end

  assign mul_start = (state == S_RWAIT) && div_stat.done;

  tps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  tps_multiplier u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (div_quo),
    .mplier  (period),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  // Next state of the search sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_RECIP;
      S_RECIP:  state_next = S_RWAIT;
      S_RWAIT:  if (div_stat.done) state_next = S_MUL;
      S_MUL:    if (mul_stat.done) state_next = S_CHECK;
      S_CHECK:  state_next = (tm1 > tps_pkg::TOP_LIMIT) ? S_FINISH : S_PDIV;
      S_PDIV:   state_next = S_PWAIT;
      S_PWAIT:  if (div_stat.done) state_next = S_EVAL;
      S_EVAL: begin
        if (err == 32'd0 || k == '0) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_RECIP;
        end
      end
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath: operands, tick count, period product, error and best pick.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      period   <= period_ms;
      clk_hz   <= clock_hz;
      k        <= tps_pkg::IdxW'(tps_pkg::NumPresc - 1);
      found    <= 1'b0;
      best_err <= '1;
      best_idx <= '0;
      best_top <= '0;
    end
    if (state == S_MUL && mul_stat.done) begin
      ticks <= mul_prod[63:32];
    end
    if (state == S_CHECK) begin
      pprod <= tps_pkg::ProdW'(tps_pkg::DIV_TABLE[k] * ticks[16:0]);
    end
    if (state == S_PWAIT && div_stat.done) begin
      err <= pdiff[31] ? (32'd0 - pdiff) : pdiff;
    end
    if (state == S_EVAL) begin
      // An exact match or a strictly smaller error takes over; ties keep the older one.
      if (err == 32'd0 || err < best_err) begin
        found    <= 1'b1;
        best_err <= err;
        best_idx <= k;
        best_top <= tm1[15:0];
      end
      if (err != 32'd0 && k != '0) begin
        k <= k - 1'b1;
      end
    end
  end

  // Output register: holds the result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      failed          <= !found;
      prescaler_index <= best_idx;
      top_value       <= best_top;
    end
  end

  // The serial units are idle whenever the block is ready for a new beat.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy && !mul_stat.busy)
    else $error("serial unit busy while idle");

  // Divider results arrive only while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_RWAIT || state == S_PWAIT))
    else $error("unexpected divider result");

  // Multiplier results arrive only while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> state == S_MUL)
    else $error("unexpected multiplier result");

  // A failed result carries zero index and zero top value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> prescaler_index == '0 && top_value == '0)
    else $error("failed result with nonzero fields");

  // Only a usable tick count reaches the error evaluation.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> tm1 <= tps_pkg::TOP_LIMIT)
    else $error("unusable tick count evaluated");

endmodule

[test/tb.sv]
// Self-checking testbench for the timer prescaler search block.
// Drives period/clock beats through directed rows and random items, checks every result beat.
// Depends only on timer_prescaler_top_search and its package tps_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One result beat as the block reports it.
  typedef struct packed {
    logic        failed;
    logic [2:0]  idx;
    logic [15:0] top;
  } setting_t;

  // One row of the directed stimulus table.
  typedef struct packed {
    logic [31:0] per;
    logic [31:0] hz;
    logic        typed;
    setting_t    res;
  } stim_row_t;

  localparam logic [2:0]  IDX_DIV1      = 3'd0;
  localparam logic [2:0]  IDX_DIV1024   = 3'd7;
  localparam setting_t    NO_SETTING    = {1'b1, IDX_DIV1, 16'd0};
  localparam int          NUM_RANDOM    = 520;
  localparam int          QUIET_LIMIT   = 20000;
  localparam int          HOLD_CYCLES   = 4000;
  localparam int          DRAIN_CYCLES  = 1200;
  localparam int          IDLE_PCT      = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] period_ms = '0;
  logic [31:0] clock_hz = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        failed;
  logic [2:0]  prescaler_index;
  logic [15:0] top_value;

  // Expectation that travels with the offered beat; driven like the payload.
  setting_t    offered_setting = '0;
  logic        calm = 1'b0;
  logic        hold_go = 1'b0;

  setting_t    pending_settings [$];
  stim_row_t   dir_rows [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;

  timer_prescaler_top_search dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .period_ms       (period_ms),
    .clock_hz        (clock_hz),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .failed          (failed),
    .prescaler_index (prescaler_index),
    .top_value       (top_value)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Search prescalers from the largest down and keep the closest achieved period.
  function automatic setting_t predict_setting(logic [31:0] per, logic [31:0] hz);
    setting_t    best;
    logic [63:0] divisor;
    logic [63:0] recip;
    logic [63:0] prod;
    logic [63:0] achieved;
    logic [31:0] ticks;
    logic [31:0] ticks_m1;
    logic [31:0] diff;
    logic [31:0] err;
    logic [31:0] best_err;
    logic        found;
    logic        searching;
    int          k;
    found     = 1'b0;
    searching = 1'b1;
    best_err  = 32'hFFFF_FFFF;
    best      = NO_SETTING;
    for (k = 7; k >= 0 && searching; k--) begin
      case (k)
        0: divisor = 64'd1000;
        1: divisor = 64'd2000;
        2: divisor = 64'd4000;
        3: divisor = 64'd8000;
        4: divisor = 64'd16000;
        5: divisor = 64'd64000;
        6: divisor = 64'd256000;
        default: divisor = 64'd1024000;
      endcase
      recip    = {hz, 32'd0} / divisor;
      prod     = recip * {32'd0, per};
      ticks    = prod[63:32];
      ticks_m1 = ticks - 32'd1;
      if (ticks_m1 > tps_pkg::TOP_LIMIT) begin
        searching = 1'b0;
      end else begin
        // A zero clock gives zero ticks, so the division below never sees zero.
        achieved = (divisor * {32'd0, ticks}) / {32'd0, hz};
        diff     = achieved[31:0] - per;
        err      = diff[31] ? (32'd0 - diff) : diff;
        if (err == 32'd0 || err < best_err) begin
          found    = 1'b1;
          best_err = err;
          best.idx = k[2:0];
          best.top = ticks_m1[15:0];
        end
        if (err == 32'd0) begin
          searching = 1'b0;
        end
      end
    end
    if (found) begin
      best.failed = 1'b0;
    end
    return best;
  endfunction

  task automatic add_row(logic [31:0] per, logic [31:0] hz, logic typed, setting_t res);
    stim_row_t row;
    row.per   = per;
    row.hz    = hz;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Offer one beat, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_beat(logic [31:0] per, logic [31:0] hz, setting_t exp);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    period_ms       <= per;
    clock_hz        <= hz;
    offered_setting <= exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off, and a calm stretch.
  int   hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Record accepted beats, check result beats, and watch for a hang.
  always @(posedge clk) begin
    setting_t exp;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_settings.push_back(offered_setting);
      end
      if (out_valid && out_ready) begin
        if (pending_settings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result beat: failed=%0d index=%0d top=%0d",
                     failed, prescaler_index, top_value);
          end
        end else begin
          exp = pending_settings.pop_front();
          if (failed !== exp.failed || prescaler_index !== exp.idx ||
              top_value !== exp.top) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result mismatch: expected failed=%0d index=%0d top=%0d, got failed=%0d index=%0d top=%0d",
                       exp.failed, exp.idx, exp.top, failed, prescaler_index, top_value);
            end
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Sender: reset, directed table, then random items.
  initial begin
    logic [31:0] per;
    logic [31:0] hz;
    longint      lo;
    longint      hi;
    int          sel;
    setting_t    exp;

    // Typed rows: zero clock, zero period, zero ticks, exact fits at the edges of the counter.
    add_row(32'd0,          32'd0,          1'b1, NO_SETTING);
    add_row(32'hFFFF_FFFF,  32'd0,          1'b1, NO_SETTING);
    add_row(32'd0,          32'hFFFF_FFFF,  1'b1, NO_SETTING);
    add_row(32'd1,          32'd1000,       1'b1, NO_SETTING);
    add_row(32'd1,          32'd1024000,    1'b1, {1'b0, IDX_DIV1024, 16'd0});
    add_row(32'd65536,      32'd1024000,    1'b1, {1'b0, IDX_DIV1024, 16'd65535});
    add_row(32'd65537,      32'd1024000,    1'b1, NO_SETTING);
    // Predicted rows: wide products, wrapped periods, full searches, ties.
    add_row(32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, NO_SETTING);
    add_row(32'h8000_0000,  32'h8000_0000,  1'b0, NO_SETTING);
    add_row(32'd1,          32'hFFFF_FFFF,  1'b0, NO_SETTING);
    add_row(32'hFFFF_FFFF,  32'd1,          1'b0, NO_SETTING);
    add_row(32'd1024000,    32'd1,          1'b0, NO_SETTING);
    add_row(32'd10,         32'd1000000,    1'b0, NO_SETTING);
    add_row(32'd1,          32'd48000000,   1'b0, NO_SETTING);
    add_row(32'd1000,       32'd16000000,   1'b0, NO_SETTING);
    add_row(32'd500,        32'd32768,      1'b0, NO_SETTING);
    add_row(32'd3,          32'd120000000,  1'b0, NO_SETTING);
    add_row(32'd7,          32'd8000000,    1'b0, NO_SETTING);
    add_row(32'd33,         32'd3000000,    1'b0, NO_SETTING);
    add_row(32'd1,          32'd2048000,    1'b0, NO_SETTING);
    add_row(32'h7FFF_FFFF,  32'd1024000,    1'b0, NO_SETTING);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      exp = dir_rows[i].typed ? dir_rows[i].res
                              : predict_setting(dir_rows[i].per, dir_rows[i].hz);
      send_beat(dir_rows[i].per, dir_rows[i].hz, exp);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Long hold-off at the receiver early on, a calm stretch later.
      if (n == 100) begin
        hold_go <= 1'b1;
      end
      if (n == 300) begin
        calm <= 1'b1;
      end
      if (n == 380) begin
        calm <= 1'b0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        // Realistic setups: enough ticks at the largest prescaler to search on.
        hz = $urandom_range(200000000, 1000);
        lo = (64'd1024000 + hz - 1) / hz;
        hi = (sel < 25 ? 64'd67000000 : 64'd67000000000) / hz;
        if (hi < lo) begin
          hi = lo;
        end
        per = $urandom_range(32'(hi), 32'(lo));
      end else if (sel < 65) begin
        // Clocks that are multiples of the largest divisor give exact fits when the ticks fit the counter.
        hz  = 32'd1024000 * $urandom_range(64, 1);
        per = $urandom_range(2000, 1);
      end else if (sel < 80) begin
        hz  = $urandom_range(5000, 0);
        per = $urandom_range(100000, 0);
      end else begin
        hz  = $urandom();
        per = $urandom();
      end
      send_beat(per, hz, predict_setting(per, hz));
    end
    in_valid <= 1'b0;

    // Drain, then allow for a straggling beat.
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
